>>> sv/gram_matrix_multiply_macros.svh
// Assertion macros shared by the Gram matrix block; they sample on clk and hold off during rst.
`ifndef GRAM_MATRIX_MULTIPLY_MACROS_SVH
`define GRAM_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication.
`define GMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gram matrix check failed");

// Next-cycle implication.
`define GMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gram matrix check failed");

`endif

>>> sv/gmm_pkg.sv
// Shared types and constants for the Gram matrix block.
package gmm_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  localparam int VALUE_W   = 35;  // result entry width
  localparam int IDX_W     = 3;   // row / column index width
  localparam int LOAD_W    = 7;   // element counter width
  localparam int CFG_W     = 4;   // dimension register width
  localparam int CFG_IDX_W = 1;   // register index width

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // Tag that rides along with each pair of operands through the MAC pipe.
  typedef struct packed {
    logic             first;       // first term of a dot product
    logic             last;        // last term of a dot product
    logic             last_entry;  // last term of the final entry
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } gmm_tag_t;

endpackage

>>> sv/gmm_mac.sv
// Multiply-accumulate unit with the result output register of the Gram matrix block.
`include "gram_matrix_multiply_macros.svh"

module gmm_mac #(
  parameter int ELEM_WIDTH = gmm_pkg::DEF_ELEM_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  gmm_pkg::gmm_tag_t          s1_tag,
  input  logic [ELEM_WIDTH-1:0]      rd_a,
  input  logic [ELEM_WIDTH-1:0]      rd_b,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gmm_pkg::VALUE_W-1:0] product_value,
  output logic [gmm_pkg::IDX_W-1:0]  out_row,
  output logic [gmm_pkg::IDX_W-1:0]  out_col,
  output logic                       last_entry
);
  import gmm_pkg::*;

  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic                     p_valid;
  gmm_tag_t                 p_tag;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       prod_ext;
  logic [VALUE_W-1:0]       acc;
  logic [VALUE_W-1:0]       sum;

  assign busy     = p_valid;
  assign prod_ext = 64'(prod);
  // Sum modulo 2^35: only the low bits of the extended product matter.
  assign sum = (p_tag.first ? '0 : acc) + prod_ext[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= s1_valid;
      if (p_valid && p_tag.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_tag <= s1_tag;
    prod  <= $signed(rd_a) * $signed(rd_b);
    if (p_valid) begin
      acc <= sum;
    end
    if (p_valid && p_tag.last) begin
      product_value <= sum;
      out_row       <= p_tag.row;
      out_col       <= p_tag.col;
      last_entry    <= p_tag.last_entry;
    end
  end

  `GMM_ASSERT_NOW(a_out_free_on_finish, p_valid && p_tag.last, !out_valid || out_ready)
  `GMM_ASSERT_NEXT(a_finish_shows, p_valid && p_tag.last, out_valid)
  `GMM_ASSERT_NOW(a_final_is_last_term, p_valid && p_tag.last_entry, p_tag.last)

endmodule

>>> sv/gram_matrix_multiply.sv
// Gram matrix block: loads a signed matrix A element by element and emits A times A-transpose.
// Load: one element per cycle; in_ready is high whenever the sequencer is idle.
// Compute: one shared MAC, one term per cycle while in S_ISSUE; each entry issues its cols
// terms, then the last term is read, multiplied and accumulated while the pipe drains.
// Reset: control, the load counter and both dimension registers (to 8) reset at once; no clearing pass.
`include "gram_matrix_multiply_macros.svh"

module gram_matrix_multiply #(
  parameter int MAX_DIM    = gmm_pkg::DEF_MAX_DIM,
  parameter int ELEM_WIDTH = gmm_pkg::DEF_ELEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmm_pkg::CFG_W-1:0]     cfg_data,
  // element request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ELEM_WIDTH-1:0]         element,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gmm_pkg::VALUE_W-1:0]   product_value,
  output logic [gmm_pkg::IDX_W-1:0]     out_row,
  output logic [gmm_pkg::IDX_W-1:0]     out_col,
  output logic                          last_entry
);
  import gmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    S_LOAD,   // take elements
    S_WAIT,   // hold until the MAC pipe and output register are free
    S_ISSUE   // read one pair of operands per cycle
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  rows_in_use;
  logic [CFG_W-1:0]  cols_in_use;
  logic [DIM_W-1:0]  rows_c;
  logic [DIM_W-1:0]  cols_c;
  logic [DIM_W-1:0]  rows_m1;
  logic [DIM_W-1:0]  cols_m1;
  logic [2*DIM_W-1:0] total;

  logic [LOAD_W-1:0] load_count;
  logic [LOAD_W-1:0] cnt_inc;
  logic              done;

  // sequencer counters
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [ADDR_W-1:0] a_base;
  logic [ADDR_W-1:0] b_base;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic              i_last;
  logic              j_last;
  logic              k_last;
  logic              go;

  logic              iss_valid;
  gmm_tag_t          iss_tag;

  // operand store and its registered read ports
  logic [ELEM_WIDTH-1:0] store [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a;
  logic [ELEM_WIDTH-1:0] rd_b;
  logic                  s1_valid;
  gmm_tag_t              s1_tag;
  logic                  mac_busy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_LOAD);

  // Saturate the dimensions: zero acts as one, anything above MAX_DIM as MAX_DIM.
  always_comb begin
    if (rows_in_use == '0) begin
      rows_c = DIM_W'(1);
    end else if (rows_in_use > CFG_W'(MAX_DIM)) begin
      rows_c = DIM_W'(MAX_DIM);
    end else begin
      rows_c = DIM_W'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      cols_c = DIM_W'(1);
    end else if (cols_in_use > CFG_W'(MAX_DIM)) begin
      cols_c = DIM_W'(MAX_DIM);
    end else begin
      cols_c = DIM_W'(cols_in_use);
    end
  end

  assign rows_m1 = rows_c - DIM_W'(1);
  assign cols_m1 = cols_c - DIM_W'(1);
  assign total   = (2*DIM_W)'(rows_c) * (2*DIM_W)'(cols_c);

  // The counter wraps at 128; the matrix is complete once it reaches rows*cols.
  assign cnt_inc = load_count + LOAD_W'(1);
  assign done    = (cnt_inc >= LOAD_W'(total));

  assign i_last = (CFG_W'(i) == CFG_W'(rows_m1));
  assign j_last = (CFG_W'(j) == CFG_W'(rows_m1));
  assign k_last = (CFG_W'(k) == CFG_W'(cols_m1));
  assign addr_a = a_base + ADDR_W'(k);
  assign addr_b = b_base + ADDR_W'(k);

  // Start an entry only with an empty pipe and a free (or draining) output register,
  // so its result can always land in the output register.
  assign go = !s1_valid && !mac_busy && (!out_valid || out_ready);

  assign iss_valid          = (state == S_ISSUE);
  assign iss_tag.first      = (k == '0);
  assign iss_tag.last       = k_last;
  assign iss_tag.last_entry = k_last && j_last && i_last;
  assign iss_tag.row        = i;
  assign iss_tag.col        = j;

  // Sequencer, dimension registers and load counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      load_count  <= '0;
      rows_in_use <= DIM_RESET;
      cols_in_use <= DIM_RESET;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= iss_valid;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROWS: rows_in_use <= cfg_data;
          CFG_COLS: cols_in_use <= cfg_data;
        endcase
      end
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (done) begin
              load_count <= '0;
              i          <= '0;
              j          <= '0;
              a_base     <= '0;
              b_base     <= '0;
              state      <= S_WAIT;
            end else begin
              load_count <= cnt_inc;
            end
          end
        end
        S_WAIT: begin
          if (go) begin
            k     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          k <= k + IDX_W'(1);
          if (k_last) begin
            if (j_last) begin
              if (i_last) begin
                // final entry issued: take the next matrix while it drains
                state <= S_LOAD;
              end else begin
                i      <= i + IDX_W'(1);
                j      <= '0;
                a_base <= a_base + ADDR_W'(cols_c);
                b_base <= '0;
                state  <= S_WAIT;
              end
            end else begin
              j      <= j + IDX_W'(1);
              b_base <= b_base + ADDR_W'(cols_c);
              state  <= S_WAIT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Operand store: one write port for loading, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && (load_count < LOAD_W'(DEPTH))) begin
      store[load_count[ADDR_W-1:0]] <= element;
    end
    rd_a   <= store[addr_a];
    rd_b   <= store[addr_b];
    s1_tag <= iss_tag;
  end

  gmm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_tag        (s1_tag),
    .rd_a          (rd_a),
    .rd_b          (rd_b),
    .busy          (mac_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_entry    (last_entry)
  );

  `GMM_ASSERT_NOW(a_addr_in_range, iss_valid, (addr_a < ADDR_W'(DEPTH - 1)) || (addr_a == ADDR_W'(DEPTH - 1)))
  `GMM_ASSERT_NOW(a_last_on_diagonal, out_valid && last_entry, out_row == out_col)
  `GMM_ASSERT_NEXT(a_busy_after_fill, in_valid && in_ready && done, !in_ready)

endmodule

>>> sim/tb_gram_matrix_multiply.sv
// Self-checking testbench for gram_matrix_multiply: streamed matrices, A*A^T predicted and compared.
module tb_gram_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import gmm_pkg::*;

  localparam int ELEM_W       = DEF_ELEM_WIDTH;
  localparam int MAX_DIM      = DEF_MAX_DIM;
  localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ITEM_TARGET  = 370;      // minimum number of elements to send
  localparam int SETTLE       = 16;       // idle cycles before a register write
  localparam int TAIL         = 50;       // idle cycles after the last entry
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int END_WAIT     = 20000;    // bound on the drain at the end
  localparam int CYCLE_LIMIT  = 1000000;

  // Kinds of request in the stimulus queue. Markers steer the driver; only
  // REQ_ELEMENT and REQ_WRITE reach the block's ports.
  typedef enum logic [1:0] {
    REQ_ELEMENT,
    REQ_WRITE,
    REQ_PAUSE,   // wait until every expected entry has come back
    REQ_HOLD     // start the long receiver hold-off
  } req_kind_t;

  typedef struct {
    req_kind_t          kind;
    logic [ELEM_W-1:0]  value;
    cfg_idx_t           reg_idx;
    logic [CFG_W-1:0]   reg_data;
    int                 gap;       // idle cycles before this request is offered
  } request_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               is_last;
  } gram_entry_t;

  // Block ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ELEM_W-1:0]    element = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   product_value;
  logic [IDX_W-1:0]     out_row;
  logic [IDX_W-1:0]     out_col;
  logic                 last_entry;

  // Stimulus and expectation stores.
  request_t    request_queue[$];
  gram_entry_t pending_entries[$];

  // Predictor state: the block's store, load counter and dimension registers.
  logic signed [ELEM_W-1:0] elem_store [STORE_DEPTH];
  logic [LOAD_W-1:0]        load_cnt = '0;
  logic [CFG_W-1:0]         dim_rows = DIM_RESET;
  logic [CFG_W-1:0]         dim_cols = DIM_RESET;

  // Dimensions as the stimulus planner sees them (already clamped).
  int plan_rows = MAX_DIM;
  int plan_cols = MAX_DIM;

  int   element_total = 0;
  int   write_total = 0;
  int   entries_checked = 0;
  int   mismatch_count = 0;
  int   quiet = 0;          // cycles with nothing expected and no handshake
  int   gap_count = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   sink_mode = 0;
  logic hold_kick = 1'b0;

  gram_matrix_multiply dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element       (element),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_entry    (last_entry)
  );

  always #4 clk = ~clk;

  // A dimension register of 0 acts as 1; anything above MAX_DIM acts as MAX_DIM.
  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // Store one element; when it completes the matrix, queue every entry of A*A^T
  // in row-major order.
  task automatic load_and_multiply(logic [ELEM_W-1:0] el);
    int          r;
    int          c;
    int          total;
    longint      acc;
    gram_entry_t e;
    r = clamp_dim(dim_rows);
    c = clamp_dim(dim_cols);
    total = r * c;
    if (load_cnt < STORE_DEPTH) elem_store[load_cnt] = el;
    load_cnt = load_cnt + 1'b1;
    // A shrink during a load can leave the counter at or past the new total.
    if (load_cnt < total) return;
    load_cnt = '0;
    for (int i = 0; i < r; i++) begin
      for (int j = 0; j < r; j++) begin
        acc = 0;
        for (int k = 0; k < c; k++) begin
          acc += longint'(elem_store[(i * c + k) % STORE_DEPTH]) *
                 longint'(elem_store[(j * c + k) % STORE_DEPTH]);
        end
        e.value   = acc[VALUE_W-1:0];
        e.row     = i[IDX_W-1:0];
        e.col     = j[IDX_W-1:0];
        e.is_last = (i == r - 1) && (j == r - 1);
        pending_entries.push_back(e);
      end
    end
  endtask

  // Sender gaps: none, short, or short with the odd long one.
  function automatic int pick_gap(int mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      0: return 0;
      1: return (roll < 70) ? 0 : $urandom_range(1, 3);
      default: begin
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
      end
    endcase
  endfunction

  // Mix extremes, tiny values and full-range noise so every bit toggles.
  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(9))
      0: return {1'b1, {(ELEM_W-1){1'b0}}};
      1: return {1'b0, {(ELEM_W-1){1'b1}}};
      2: return ELEM_W'($urandom_range(15)) - ELEM_W'(8);
      3: return {ELEM_W{$urandom_range(1) == 1}};
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  task automatic queue_element(logic [ELEM_W-1:0] v, int gap);
    request_t req;
    req.kind  = REQ_ELEMENT;
    req.value = v;
    req.gap   = gap;
    request_queue.push_back(req);
    element_total++;
  endtask

  task automatic queue_write(cfg_idx_t idx, logic [CFG_W-1:0] data);
    request_t req;
    req.kind     = REQ_WRITE;
    req.reg_idx  = idx;
    req.reg_data = data;
    req.gap      = 0;
    request_queue.push_back(req);
    if (idx == CFG_ROWS) plan_rows = clamp_dim(data);
    else plan_cols = clamp_dim(data);
  endtask

  task automatic queue_marker(req_kind_t kind);
    request_t req;
    req.kind = kind;
    req.gap  = 0;
    request_queue.push_back(req);
  endtask

  // Write both dimensions, sometimes through the out-of-range encodings.
  task automatic queue_dims(int r, int c);
    logic [CFG_W-1:0] raw_r;
    logic [CFG_W-1:0] raw_c;
    raw_r = CFG_W'(r);
    raw_c = CFG_W'(c);
    if (r == 1 && $urandom_range(1) == 1) raw_r = '0;
    if (r == MAX_DIM && $urandom_range(1) == 1) raw_r = CFG_W'($urandom_range(9, 15));
    if (c == 1 && $urandom_range(1) == 1) raw_c = '0;
    if (c == MAX_DIM && $urandom_range(1) == 1) raw_c = CFG_W'($urandom_range(9, 15));
    queue_write(CFG_ROWS, raw_r);
    queue_write(CFG_COLS, raw_c);
  endtask

  task automatic queue_matrix(int mode);
    repeat (plan_rows * plan_cols) queue_element(rand_element(), pick_gap(mode));
  endtask

  // Driver: offer the head request once its gap has passed. Register writes
  // and pauses wait for the block to go quiet. Next values are worked out in
  // locals so each valid gets exactly one assignment per edge.
  always @(posedge clk) begin
    request_t head;
    logic     nxt_in;
    logic     nxt_cfg;
    logic     nxt_kick;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      hold_kick <= 1'b0;
      gap_count <= 0;
    end else begin
      nxt_in   = in_valid && !in_ready;
      nxt_cfg  = cfg_valid && !cfg_ready;
      nxt_kick = 1'b0;
      if (!nxt_in && !nxt_cfg && request_queue.size() != 0) begin
        head = request_queue[0];
        if (gap_count < head.gap) begin
          gap_count <= gap_count + 1;
        end else begin
          case (head.kind)
            REQ_ELEMENT: begin
              element <= head.value;
              nxt_in = 1'b1;
              gap_count <= 0;
              void'(request_queue.pop_front());
            end
            REQ_WRITE: begin
              // Hold the write until nothing is due and the block has settled.
              if (!in_valid && !cfg_valid && quiet >= SETTLE) begin
                cfg_index <= head.reg_idx;
                cfg_data  <= head.reg_data;
                nxt_cfg = 1'b1;
                void'(request_queue.pop_front());
              end
            end
            REQ_PAUSE: begin
              if (!in_valid && quiet >= 1) void'(request_queue.pop_front());
            end
            REQ_HOLD: begin
              nxt_kick = 1'b1;
              void'(request_queue.pop_front());
            end
          endcase
        end
      end
      in_valid  <= nxt_in;
      cfg_valid <= nxt_cfg;
      hold_kick <= nxt_kick;
    end
  end

  // Receiver: random stalls in a randomly redrawn mix, plus one long
  // hold-off counted here so the block backs up and stalls its input.
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
      sink_mode  <= 0;
    end else begin
      if (cycle_count % 256 == 0) sink_mode <= $urandom_range(2);
      roll = $urandom_range(99);
      if (hold_kick) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (sink_mode == 1 && roll < 30) begin
        stall_left <= $urandom_range(0, 2);
        out_ready  <= 1'b0;
      end else if (sink_mode == 2 && roll < 25) begin
        stall_left <= $urandom_range(0, 3);
        out_ready  <= 1'b0;
      end else if (sink_mode == 2 && roll < 28) begin
        stall_left <= $urandom_range(20, 80);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Scoreboard: predict on accepted requests, check each accepted entry
  // against the oldest expectation, and track how long things have been quiet.
  always @(posedge clk) begin
    gram_entry_t want;
    logic        cfg_acc;
    logic        in_acc;
    logic        out_acc;
    if (!rst) begin
      cfg_acc = cfg_valid && cfg_ready;
      in_acc  = in_valid && in_ready;
      out_acc = out_valid && out_ready;
      if (cfg_acc) begin
        write_total++;
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS: dim_rows = cfg_data;
          CFG_COLS: dim_cols = cfg_data;
        endcase
      end
      if (in_acc) load_and_multiply(element);
      if (out_acc) begin
        entries_checked++;
        if (pending_entries.size() == 0) begin
          report_mismatch($sformatf("entry (%0d,%0d) value %0d arrived with none due",
                                    out_row, out_col, $signed(product_value)));
        end else begin
          want = pending_entries.pop_front();
          if (product_value !== want.value)
            report_mismatch($sformatf("entry (%0d,%0d): value %0d, expected %0d",
                                      want.row, want.col, $signed(product_value),
                                      $signed(want.value)));
          if (out_row !== want.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", out_row, want.row));
          if (out_col !== want.col)
            report_mismatch($sformatf("out_col %0d, expected %0d", out_col, want.col));
          if (last_entry !== want.is_last)
            report_mismatch($sformatf("entry (%0d,%0d): last_entry %0b, expected %0b",
                                      want.row, want.col, last_entry, want.is_last));
        end
      end
      if (pending_entries.size() != 0 || cfg_acc || in_acc || out_acc) quiet <= 0;
      else if (quiet < CYCLE_LIMIT) quiet <= quiet + 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still due",
               cycle_count, pending_entries.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int mode;
    int k;
    int r;
    int c;
    int phase;
    int big_count;
    int wait_left;

    // Directed: the most negative and most positive sums, cols written as 15.
    queue_write(CFG_ROWS, CFG_W'(2));
    queue_write(CFG_COLS, CFG_W'(15));
    repeat (MAX_DIM) queue_element({1'b1, {(ELEM_W-1){1'b0}}}, 0);
    repeat (MAX_DIM) queue_element({1'b0, {(ELEM_W-1){1'b1}}}, 0);
    // Zero rows acts as one: two 1x1 matrices, zero and minus one.
    queue_write(CFG_ROWS, '0);
    queue_write(CFG_COLS, CFG_W'(1));
    queue_element('0, 0);
    queue_element('1, 1);
    // Shrink during a load: three elements in, total drops to two, the next
    // element completes the matrix.
    queue_write(CFG_ROWS, CFG_W'(1));
    queue_write(CFG_COLS, CFG_W'(8));
    repeat (3) queue_element(rand_element(), 0);
    queue_write(CFG_COLS, CFG_W'(2));
    queue_element(rand_element(), 0);

    // Random phases: mostly small matrices with random content, a couple of
    // full-size ones, shrinks mid-load, and one long receiver hold-off.
    phase = 0;
    big_count = 0;
    while (element_total < ITEM_TARGET) begin
      mode = $urandom_range(2);
      k = $urandom_range(99);
      if (phase == 2) begin
        queue_dims(3, 3);
        queue_marker(REQ_HOLD);
        queue_matrix(0);
        queue_matrix(0);
        queue_marker(REQ_PAUSE);
      end else if (k < 8 && big_count < 2) begin
        big_count++;
        queue_dims(MAX_DIM, MAX_DIM);
        queue_matrix(mode);
      end else if (k < 20) begin
        // Partial load, then shrink so the next element finishes the matrix.
        queue_dims(3, 3);
        k = $urandom_range(1, 8);
        repeat (k) queue_element(rand_element(), pick_gap(mode));
        r = $urandom_range(1, (k + 1 < MAX_DIM) ? k + 1 : MAX_DIM);
        c = (k + 1) / r;
        c = $urandom_range(1, (c < MAX_DIM) ? c : MAX_DIM);
        queue_dims(r, c);
        queue_element(rand_element(), pick_gap(mode));
      end else begin
        r = $urandom_range(1, 4);
        c = ($urandom_range(3) == 0) ? $urandom_range(5, MAX_DIM) : $urandom_range(1, 4);
        queue_dims(r, c);
        repeat ($urandom_range(1, 3)) queue_matrix(mode);
      end
      if ($urandom_range(3) == 0) queue_marker(REQ_PAUSE);
      phase++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: every request taken, then nothing due for a while.
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || cfg_valid) @(negedge clk);
    wait_left = END_WAIT;
    while ((pending_entries.size() != 0 || quiet < TAIL) && wait_left > 0) begin
      @(negedge clk);
      wait_left--;
    end
    if (pending_entries.size() != 0)
      report_mismatch($sformatf("%0d expected entries never arrived",
                                pending_entries.size()));

    $display("covered %0d elements and %0d register writes, %0d product entries checked",
             element_total, write_total, entries_checked);
    $display("sizes 1x1 to 8x8, clamped dimensions, mid-load shrinks; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
